### rtl/core/ellspmv_pkg.sv
package ellspmv_pkg;

  // Default sizes of the storage.
  localparam int unsigned VECTOR_DEPTH  = 1024;
  localparam int unsigned MAX_ROW_WIDTH = 64;
  localparam int unsigned QUEUE_DEPTH   = 4;

  // Fixed field widths.
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned ROWS_W     = 11;
  localparam int unsigned WIDTH_W    = 7;
  localparam int unsigned CFG_DATA_W = 11;

  // Request kinds.
  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_ENTRY = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_NUM_ROWS  = 1'b0,
    CFG_ROW_WIDTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e                     kind;
    logic [INDEX_W-1:0]        index;
    logic                      padding;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic signed [VALUE_W-1:0] sum;
    logic                      last_row;
  } out_item_t;

  // One matrix slot on its way to the multiply-accumulate side.
  typedef struct packed {
    logic                      active;
    logic signed [VALUE_W-1:0] mat_val;
    logic signed [VALUE_W-1:0] vec_val;
  } slot_t;

  typedef struct packed {
    logic [ROWS_W-1:0]  num_rows;
    logic [WIDTH_W-1:0] row_width;
  } cfg_t;

  // Floor a Q32.32 value to Q16.16 and saturate it.
  function automatic logic signed [VALUE_W-1:0] to_q16(input logic signed [ACC_W-1:0] acc);
    logic in_range;
    in_range = (&acc[ACC_W-1:47]) | ~(|acc[ACC_W-1:47]);
    if (in_range) begin
      return acc[47:16];
    end else if (acc[ACC_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/core/ellspmv_queue.sv
module ellspmv_queue import ellspmv_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  slot_t                           push_data_i,
  input  logic                            pop_i,
  output slot_t                           pop_data_o,
  output logic                            empty_o,
  output logic [$clog2(QueueDepth+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CNT_W = $clog2(QueueDepth + 1);

  slot_t              slots_q [QueueDepth];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Pointer and fill count updates; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slots_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;

endmodule

### rtl/core/ellspmv_front.sv
module ellspmv_front import ellspmv_pkg::*; #(
  parameter int unsigned VectorDepth = VECTOR_DEPTH,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  in_item_t                        in_item_i,
  output logic                            in_stall_o,
  input  logic [$clog2(QueueDepth+1)-1:0] q_count_i,
  output logic                            push_o,
  output slot_t                           push_data_o
);

  localparam int unsigned ADDR_W = $clog2(VectorDepth);

  logic signed [VALUE_W-1:0] vec_mem [VectorDepth];

  logic                      accept;
  logic                      in_store;
  logic [ADDR_W-1:0]         addr;
  logic [31:0]               index_ext;
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_active_q;
  logic signed [VALUE_W-1:0] s1_mat_q;
  logic signed [VALUE_W-1:0] vec_rd_q;

  // Hold requests back while the queue cannot take everything in flight.
  assign in_stall_o = (32'(q_count_i) + 32'(s1_valid_q)) >= QueueDepth;
  assign accept     = in_valid_i && !in_stall_o;

  // Position decode against the store depth.
  assign index_ext = 32'(in_item_i.index);
  assign in_store  = index_ext < VectorDepth;
  assign addr      = index_ext[ADDR_W-1:0];

  // Vector store: loads write, matrix slots read one registered word.
  always_ff @(posedge clk_i) begin
    if (accept && in_store && in_item_i.kind == KIND_LOAD) begin
      vec_mem[addr] <= in_item_i.value;
    end
    if (accept && in_store && in_item_i.kind == KIND_ENTRY) begin
      vec_rd_q <= vec_mem[addr];
    end
  end

  // Classification stage: only matrix slots move on to the queue.
  assign s1_valid_d = accept && (in_item_i.kind == KIND_ENTRY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_active_q <= !in_item_i.padding && in_store;
      s1_mat_q    <= in_item_i.value;
    end
  end

  assign push_o              = s1_valid_q;
  assign push_data_o.active  = s1_active_q;
  assign push_data_o.mat_val = s1_mat_q;
  assign push_data_o.vec_val = vec_rd_q;

endmodule

### rtl/core/ellspmv_back.sv
module ellspmv_back import ellspmv_pkg::*; #(
  parameter int unsigned VectorDepth = VECTOR_DEPTH,
  parameter int unsigned MaxRowWidth = MAX_ROW_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  slot_t     q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned ENT_W = $clog2(MaxRowWidth + 1);

  logic                      mul_valid_q, mul_valid_d;
  logic signed [ACC_W-1:0]   mul_full;
  logic signed [ACC_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_new;
  logic [ENT_W-1:0]          ent_q, ent_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [31:0]               width_eff;
  logic [31:0]               rows_eff;
  logic                      row_end;
  logic                      last;
  logic                      acc_fire;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_item_q;

  // Effective register values, clamped to their legal ranges.
  always_comb begin
    width_eff = 32'(cfg_i.row_width);
    if (width_eff == 0) begin
      width_eff = 32'd1;
    end else if (width_eff > MaxRowWidth) begin
      width_eff = MaxRowWidth;
    end
    rows_eff = 32'(cfg_i.num_rows);
    if (rows_eff == 0) begin
      rows_eff = 32'd1;
    end else if (rows_eff > VectorDepth) begin
      rows_eff = VectorDepth;
    end
  end

  assign row_end = (32'(ent_q) + 32'd1) >= width_eff;
  assign last    = (32'(row_q) + 32'd1) >= rows_eff;

  // The accumulate step waits only when it would finish a row into a full output.
  assign acc_fire = mul_valid_q && (!row_end || !out_valid_q || !out_stall_i);
  assign pop_o    = !q_empty_i && (!mul_valid_q || acc_fire);

  // Multiply stage.
  always_comb begin
    mul_valid_d = mul_valid_q;
    if (pop_o) begin
      mul_valid_d = 1'b1;
    end else if (acc_fire) begin
      mul_valid_d = 1'b0;
    end
  end

  // Full-width signed product of the matrix value and the vector element.
  assign mul_full = $signed(q_data_i.mat_val) * $signed(q_data_i.vec_val);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= q_data_i.active ? mul_full : '0;
    end
  end

  // Saturating 64-bit accumulate.
  always_comb begin
    acc_sum = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // Row bookkeeping and the output register.
  always_comb begin
    acc_d       = acc_q;
    ent_d       = ent_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (acc_fire) begin
      if (row_end) begin
        acc_d       = '0;
        ent_d       = '0;
        row_d       = last ? '0 : row_q + 1'b1;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_new;
        ent_d = ent_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      acc_q       <= '0;
      ent_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= mul_valid_d;
      acc_q       <= acc_d;
      ent_q       <= ent_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && row_end) begin
      out_item_q.row      <= row_q;
      out_item_q.sum      <= to_q16(acc_new);
      out_item_q.last_row <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/core/ell_sparse_matvec.sv
// A slot passes the front register, queue and product register into the row sum.
// Throughput: one request per cycle while in_stall_o is low, loads and matrix slots
// alike; the single-port vector memory does one read or one write per request.
// A 4-deep slot queue splits the memory side from the multiply-accumulate side.
// Reset clears the counters, the accumulator, the queue and the registers (rows 1,
// width 1); the vector memory is not cleared and holds nothing until loaded.
module ell_sparse_matvec import ellspmv_pkg::*; #(
  parameter int unsigned VectorDepth = VECTOR_DEPTH,
  parameter int unsigned MaxRowWidth = MAX_ROW_WIDTH,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(QueueDepth + 1);

  cfg_t             cfg_q;
  logic             q_push;
  slot_t            q_push_data;
  logic             q_pop;
  slot_t            q_pop_data;
  logic             q_empty;
  logic [CNT_W-1:0] q_count;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_rows  <= ROWS_W'(1);
      cfg_q.row_width <= WIDTH_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_ROWS:  cfg_q.num_rows  <= cfg_data_i[ROWS_W-1:0];
        CFG_ROW_WIDTH: cfg_q.row_width <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  ellspmv_front #(
    .VectorDepth (VectorDepth),
    .QueueDepth  (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .q_count_i   (q_count),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  ellspmv_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  ellspmv_back #(
    .VectorDepth (VectorDepth),
    .MaxRowWidth (MaxRowWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_pop_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted matrix slot enters the queue on the next cycle.
  a_slot_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_ENTRY |=> q_push)
    else $error("accepted matrix slot was not queued");

  // A vector load never reaches the queue.
  a_load_not_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_LOAD |=> !q_push)
    else $error("vector load was queued");

  // The queue is never written while full unless a slot is popped in the same cycle.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (32'(q_count) < QueueDepth) || q_pop)
    else $error("slot queue overflow");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("slot queue underflow");

endmodule

### tb/sv/ell_sparse_matvec_test.sv
module ell_sparse_matvec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ellspmv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned ITEM_TARGET  = 1150;

  // Bounds of the Q16.16 range seen from the Q32.32 accumulator.
  localparam logic signed [ACC_W-1:0] Q16_TOP = 64'sh0000_8000_0000_0000;
  localparam logic signed [ACC_W-1:0] Q16_BOT = 64'shFFFF_8000_0000_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  in_item_t              in_item   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  cfg_reg_e              cfg_index = CFG_NUM_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready;

  // Shadow state of the matrix-vector engine.
  logic signed [VALUE_W-1:0] vec_mem [VECTOR_DEPTH];
  logic signed [ACC_W-1:0]   dot_acc   = '0;
  int unsigned               slot_cnt  = 0;
  int unsigned               cur_row   = 0;
  logic [ROWS_W-1:0]         rows_reg  = ROWS_W'(1);
  logic [WIDTH_W-1:0]        width_reg = WIDTH_W'(1);

  out_item_t   row_sum_q [$];
  out_item_t   next_sum;
  in_item_t    pending_q [$];
  bit          vec_written [VECTOR_DEPTH];
  int unsigned written_cols [$];

  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned sat_cnt      = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;
  bit          burst_mode   = 1'b0;

  ell_sparse_matvec u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Advance the shadow state by one accepted request and queue any row sum it completes.
  task automatic step_matvec(input in_item_t req);
    logic signed [VALUE_W-1:0] mat_v;
    logic signed [VALUE_W-1:0] vec_v;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   total;
    int unsigned               eff_w;
    int unsigned               eff_rows;
    bit                        wrap;
    out_item_t                 res;
    if (req.kind == KIND_LOAD) begin
      vec_mem[req.index] = req.value;
      return;
    end
    if (!req.padding) begin
      mat_v = req.value;
      vec_v = vec_mem[req.index];
      prod  = mat_v * vec_v;
      total = dot_acc + prod;
      // Same-sign operands with a flipped result sign mean the 64-bit sum overflowed.
      if (dot_acc[ACC_W-1] == prod[ACC_W-1] && total[ACC_W-1] != prod[ACC_W-1]) begin
        total = prod[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      dot_acc = total;
    end
    eff_w    = (width_reg == 0) ? 1 : (width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : width_reg;
    eff_rows = (rows_reg == 0) ? 1 : (rows_reg > VECTOR_DEPTH) ? VECTOR_DEPTH : rows_reg;
    slot_cnt++;
    if (slot_cnt < eff_w) begin
      return;
    end
    wrap    = (cur_row + 1 >= eff_rows);
    res.row = ROW_W'(cur_row);
    // Floor to Q16.16 by dropping the low 16 fraction bits, saturating outside the range.
    if (dot_acc >= Q16_TOP) begin
      res.sum = {1'b0, {(VALUE_W-1){1'b1}}};
      sat_cnt++;
    end else if (dot_acc < Q16_BOT) begin
      res.sum = {1'b1, {(VALUE_W-1){1'b0}}};
      sat_cnt++;
    end else begin
      res.sum = dot_acc[47:16];
    end
    res.last_row = wrap;
    row_sum_q.push_back(res);
    dot_acc  = '0;
    slot_cnt = 0;
    cur_row  = wrap ? 0 : ((cur_row + 1) & 32'h3FF);
  endtask

  // Queue one request for the driver and track which vector positions hold data.
  function automatic void queue_request(input kind_e kind, input int unsigned idx,
                                        input bit pad, input logic [VALUE_W-1:0] v);
    in_item_t it;
    it.kind    = kind;
    it.index   = INDEX_W'(idx);
    it.padding = pad;
    it.value   = v;
    pending_q.push_back(it);
    pushed_cnt++;
    if (kind == KIND_LOAD && !vec_written[idx]) begin
      vec_written[idx] = 1'b1;
      written_cols.push_back(idx);
    end
  endfunction

  // Values lean toward small magnitudes so that many row sums stay in range.
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4, 5: return r;
      default: return {{14{r[17]}}, r[17:0]};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rows();
    case ($urandom_range(7))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(1024);
      3:       return CFG_DATA_W'(2047);
      4:       return CFG_DATA_W'($urandom_range(1025, 2046));
      default: return CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(7))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(64);
      3:       return CFG_DATA_W'(127);
      4:       return CFG_DATA_W'($urandom_range(65, 126));
      default: return CFG_DATA_W'($urandom_range(2, 6));
    endcase
  endfunction

  // Write one register through the configuration channel and mirror it in the shadow state.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_ROWS) begin
      rows_reg = data;
    end else begin
      width_reg = data[WIDTH_W-1:0];
    end
    cfg_cnt++;
  endtask

  // Wait until every request is taken and every row sum has come out, then let a
  // partly filled row finish moving through the pipeline.
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || row_sum_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: holds a stalled request steady and idles at random between requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        step_matvec(in_item);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
          in_item  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each row sum with the oldest prediction and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (row_sum_q.size() == 0) begin
          $display("%0t: unexpected row sum, expected none, actual row %0d sum %h last %0b",
                   $time, out_item.row, out_item.sum, out_item.last_row);
          error_cnt++;
        end else begin
          next_sum = row_sum_q.pop_front();
          result_cnt++;
          if (out_item.row !== next_sum.row) begin
            $display("%0t: row mismatch, expected %0d, actual %0d",
                     $time, next_sum.row, out_item.row);
            error_cnt++;
          end
          if (out_item.sum !== next_sum.sum) begin
            $display("%0t: sum mismatch on row %0d, expected %h, actual %h",
                     $time, next_sum.row, next_sum.sum, out_item.sum);
            error_cnt++;
          end
          if (out_item.last_row !== next_sum.last_row) begin
            $display("%0t: last_row mismatch on row %0d, expected %0b, actual %0b",
                     $time, next_sum.row, next_sum.last_row, out_item.last_row);
            error_cnt++;
          end
        end
      end
      out_stall <= !burst_mode && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n_items;
    int unsigned sel;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings give one-slot rows in a one-row matrix, so every slot is a row.
    queue_request(KIND_LOAD, 0, 1'b0, 32'h7FFF_FFFF);
    queue_request(KIND_LOAD, VECTOR_DEPTH - 1, 1'b0, 32'h8000_0000);
    queue_request(KIND_LOAD, 5, 1'b0, 32'h0001_0000);
    // The padding bit must be ignored on a load.
    queue_request(KIND_LOAD, 6, 1'b1, 32'h0000_0001);
    queue_request(KIND_ENTRY, 0, 1'b0, 32'h7FFF_FFFF);
    queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b0, 32'h8000_0000);
    queue_request(KIND_ENTRY, 0, 1'b0, 32'h8000_0000);
    queue_request(KIND_ENTRY, 5, 1'b0, 32'h0001_8000);
    // A tiny negative product must round down to -1 LSB, not toward zero.
    queue_request(KIND_ENTRY, 6, 1'b0, 32'hFFFF_FFFF);
    queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b1, 32'h7FFF_FFFF);
    wait_idle();

    // Two rows of five slots that push the accumulator past both 64-bit limits and
    // back, so a wrapping accumulator gives a different sum than a saturating one.
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(2));
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(5));
    repeat (2) queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b0, 32'h8000_0000);
    repeat (2) queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b0, 32'h7FFF_FFFF);
    queue_request(KIND_ENTRY, 0, 1'b1, 32'h7FFF_FFFF);
    repeat (3) queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b0, 32'h7FFF_FFFF);
    repeat (2) queue_request(KIND_ENTRY, VECTOR_DEPTH - 1, 1'b0, 32'h8000_0000);
    wait_idle();

    // Shrink the row width to the number of slots already taken in the current row.
    repeat (2) queue_request(KIND_ENTRY, 5, 1'b0, 32'h0001_0000);
    wait_idle();
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(2));
    queue_request(KIND_ENTRY, 5, 1'b0, 32'h0001_0000);
    wait_idle();

    // Random phases: new settings, then a mix of loads and matrix slots.
    phase = 0;
    while (pushed_cnt < ITEM_TARGET) begin
      burst_mode = (phase == 4 || phase == 5);
      case (phase)
        0: begin
          write_reg(CFG_NUM_ROWS, CFG_DATA_W'(0));
          write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(0));
        end
        1: begin
          write_reg(CFG_NUM_ROWS, CFG_DATA_W'(2047));
          write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(127));
        end
        2: begin
          write_reg(CFG_NUM_ROWS, CFG_DATA_W'(1024));
          write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(64));
        end
        default: begin
          sel = $urandom_range(3);
          if (sel != 1) begin
            write_reg(CFG_NUM_ROWS, pick_rows());
          end
          if (sel != 2) begin
            write_reg(CFG_ROW_WIDTH, pick_width());
          end
        end
      endcase
      n_items = $urandom_range(20, 80);
      repeat (n_items) begin
        if ($urandom_range(99) < 20) begin
          queue_request(KIND_LOAD, $urandom_range(VECTOR_DEPTH - 1), 1'($urandom_range(1)),
                        rand_value());
        end else begin
          // Slots only read positions that a load has already filled.
          queue_request(KIND_ENTRY, written_cols[$urandom_range(written_cols.size() - 1)],
                        $urandom_range(99) < 15, rand_value());
        end
      end
      wait_idle();
      phase++;
    end
    burst_mode = 1'b0;

    $display("Covered %0d requests in %0d phases with %0d register writes.",
             accepted_cnt, phase, cfg_cnt);
    $display("Checked %0d row sums, %0d of them saturated; %0d errors.",
             result_cnt, sat_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
